// ----- rtl/tcw_pkg.sv -----
// tcw_pkg: shared types, codes and constants of the text console cell writer
// no dependencies
`timescale 1ns / 1ps

package tcw_pkg;

   localparam int DEF_COLUMNS  = 80;
   localparam int DEF_ROWS     = 25;
   localparam int DEF_TAB_STOP = 4;

   localparam int ROW_W  = 5;
   localparam int COL_W  = 7;
   localparam int CHAR_W = 8;
   localparam int ATTR_W = 8;
   localparam int CELL_W = CHAR_W + ATTR_W;
   localparam int CSR_W  = 32;
   localparam int CSR_AW = 3;

   localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
   localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
   localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
   localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;
   localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h07;

   // register index taken from paddr[2]
   localparam logic REG_FILL_ATTR = 1'b0;

   typedef enum logic [1:0] {
      OP_PUT   = 2'd0,
      OP_SET   = 2'd1,
      OP_CLEAR = 2'd2,
      OP_READ  = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_DISPATCH,
      ST_PLAIN,
      ST_SCROLL_RD,
      ST_SCROLL_WR,
      ST_SCROLL_FILL,
      ST_CLEAR_FILL,
      ST_FINISH
   } state_type;

endpackage

// ----- rtl/tcw_ram.sv -----
// tcw_ram: generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/tcw_addr_unit.sv -----
// tcw_addr_unit: shared cell address unit, row * columns + column
// depends on tcw_pkg
`timescale 1ns / 1ps

module tcw_addr_unit
   import tcw_pkg::*;
#(
   parameter int COLUMNS = DEF_COLUMNS,
   parameter int ROWS    = DEF_ROWS
) (
   input  logic [ROW_W-1:0]                     row,
   input  logic [COL_W-1:0]                     col,
   output logic [$clog2(ROWS*COLUMNS)-1:0]      addr
);

   localparam int ADDR_W = $clog2(ROWS * COLUMNS);

   assign addr = ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col);

endmodule

// ----- rtl/text_console_cell_writer.sv -----
// text_console_cell_writer: top level, sequencer, cursor and csr around the screen ram
// depends on tcw_pkg, tcw_ram, tcw_addr_unit
//
// channel | direction | handshake             | word
// req     | in        | req_valid / req_ready | operation, char_code, row, col
// rsp     | out       | rsp_valid / rsp_ready | cur_row, cur_col, cell_char, cell_attr
// csr     | in        | apb psel / penable    | fill_attribute at byte address 0
//
// after reset the screen ram is swept once, every cell written, before req_ready rises
// set cursor and read use dispatch and finish; a put char or tab space adds a plain step
// a scroll moves rows up and fills the last row, clear fills all, one ram port per step
// req_ready is low while a word is in work; a held rsp word stalls only the finish step
`timescale 1ns / 1ps

module text_console_cell_writer
   import tcw_pkg::*;
#(
   parameter int COLUMNS  = DEF_COLUMNS,
   parameter int ROWS     = DEF_ROWS,
   parameter int TAB_STOP = DEF_TAB_STOP
) (
   input  logic              clock,
   input  logic              reset,

   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_operation,
   input  logic [CHAR_W-1:0] req_char_code,
   input  logic [ROW_W-1:0]  req_row,
   input  logic [COL_W-1:0]  req_col,

   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [ROW_W-1:0]  rsp_cur_row,
   output logic [COL_W-1:0]  rsp_cur_col,
   output logic [CHAR_W-1:0] rsp_cell_char,
   output logic [ATTR_W-1:0] rsp_cell_attr,

   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_W-1:0]  csr_pwdata,
   output logic [CSR_W-1:0]  csr_prdata,
   output logic              csr_pready
);

   localparam int CELLS  = ROWS * COLUMNS;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int TC_W   = $clog2(TAB_STOP + 1);
   localparam int COL_N  = 2 ** COL_W;

   localparam logic [ROW_W-1:0]  LAST_ROW    = ROW_W'(ROWS - 1);
   localparam logic [COL_W-1:0]  LAST_COL    = COL_W'(COLUMNS - 1);
   localparam logic [ADDR_W-1:0] SCROLL_LAST = ADDR_W'((ROWS - 1) * COLUMNS - 1);
   localparam logic [ADDR_W-1:0] CELL_LAST   = ADDR_W'(CELLS - 1);
   localparam logic [ADDR_W-1:0] ROW_STRIDE  = ADDR_W'(COLUMNS);

   // spaces a tab puts, by column
   logic [TC_W-1:0] tab_len [COL_N];

   for (genvar g = 0; g < COL_N; g++) begin : g_tab
      assign tab_len[g] = TC_W'(TAB_STOP - (g % TAB_STOP));
   end

   state_type         state_ff, state_in;
   op_type            op_ff, op_in;
   logic [CHAR_W-1:0] ch_ff, ch_in;
   logic [ROW_W-1:0]  trow_ff, trow_in;
   logic [COL_W-1:0]  tcol_ff, tcol_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [TC_W-1:0]   tab_ff, tab_in;
   logic [ADDR_W-1:0] sweep_ff, sweep_in;
   logic [ATTR_W-1:0] fill_ff, fill_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [ROW_W-1:0]  rsp_row_ff, rsp_row_in;
   logic [COL_W-1:0]  rsp_col_ff, rsp_col_in;
   logic [CHAR_W-1:0] rsp_char_ff, rsp_char_in;
   logic [ATTR_W-1:0] rsp_attr_ff, rsp_attr_in;

   logic              req_take;
   logic              out_free;
   logic              csr_wr;
   logic [ROW_W-1:0]  trow_clamp;
   logic [COL_W-1:0]  tcol_clamp;
   logic              plain_scroll;

   logic [ROW_W-1:0]  au_row;
   logic [COL_W-1:0]  au_col;
   logic [ADDR_W-1:0] au_addr;

   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [CELL_W-1:0] ram_wr_data;
   logic              ram_rd_en;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic [CELL_W-1:0] ram_rd_data;

   tcw_addr_unit #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_addr (
      .row  (au_row),
      .col  (au_col),
      .addr (au_addr)
   );

   tcw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELLS)
   ) u_screen (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_take   = req_valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign trow_clamp = (trow_ff > LAST_ROW) ? LAST_ROW : trow_ff;
   assign tcol_clamp = (tcol_ff > LAST_COL) ? LAST_COL : tcol_ff;
   assign plain_scroll = (col_ff == LAST_COL) && (row_ff == LAST_ROW);

   // csr
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign fill_in    = (csr_wr && (csr_paddr[2] == REG_FILL_ATTR)) ?
                       csr_pwdata[ATTR_W-1:0] : fill_ff;
   assign csr_prdata = (csr_paddr[2] == REG_FILL_ATTR) ?
                       CSR_W'(fill_ff) : '0;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT: begin
            if (sweep_ff == CELL_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            unique case (op_ff)
               OP_SET:   state_in = ST_FINISH;
               OP_READ:  state_in = ST_FINISH;
               OP_CLEAR: state_in = ST_CLEAR_FILL;
               OP_PUT: begin
                  priority if (ch_ff == CH_NEWLINE) begin
                     state_in = (row_ff == LAST_ROW) ? ST_SCROLL_RD : ST_FINISH;
                  end else if (ch_ff == CH_BACKSPACE) begin
                     state_in = ST_FINISH;
                  end else begin
                     state_in = ST_PLAIN;
                  end
               end
            endcase
         end
         ST_PLAIN: begin
            priority if (plain_scroll) begin
               state_in = ST_SCROLL_RD;
            end else if (tab_ff == TC_W'(1)) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_PLAIN;
            end
         end
         ST_SCROLL_RD: begin
            state_in = ST_SCROLL_WR;
         end
         ST_SCROLL_WR: begin
            state_in = (sweep_ff == SCROLL_LAST) ? ST_SCROLL_FILL : ST_SCROLL_RD;
         end
         ST_SCROLL_FILL: begin
            if (sweep_ff == CELL_LAST) begin
               state_in = (tab_ff != '0) ? ST_PLAIN : ST_FINISH;
            end
         end
         ST_CLEAR_FILL: begin
            if (sweep_ff == CELL_LAST) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath and ram controls
   always_comb begin
      op_in       = op_ff;
      ch_in       = ch_ff;
      trow_in     = trow_ff;
      tcol_in     = tcol_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      tab_in      = tab_ff;
      sweep_in    = sweep_ff;
      au_row      = row_ff;
      au_col      = col_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = au_addr;
      ram_wr_data = {fill_ff, CH_SPACE};
      ram_rd_en   = 1'b0;
      ram_rd_addr = au_addr;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_row_in  = rsp_row_ff;
      rsp_col_in  = rsp_col_ff;
      rsp_char_in = rsp_char_ff;
      rsp_attr_in = rsp_attr_ff;

      unique case (state_ff)
         ST_INIT: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = sweep_ff;
            ram_wr_data = {RESET_ATTR, CH_SPACE};
            sweep_in    = sweep_ff + ADDR_W'(1);
         end
         ST_IDLE: begin
            if (req_take) begin
               op_in   = op_type'(req_operation);
               ch_in   = req_char_code;
               trow_in = req_row;
               tcol_in = req_col;
            end
         end
         ST_DISPATCH: begin
            sweep_in = '0;
            unique case (op_ff)
               OP_SET: begin
                  row_in = trow_clamp;
                  col_in = tcol_clamp;
               end
               OP_READ: begin
                  au_row    = trow_clamp;
                  au_col    = tcol_clamp;
                  ram_rd_en = 1'b1;
               end
               OP_CLEAR: begin
                  row_in = '0;
                  col_in = '0;
               end
               OP_PUT: begin
                  priority if (ch_ff == CH_NEWLINE) begin
                     col_in = '0;
                     tab_in = '0;
                     if (row_ff != LAST_ROW) begin
                        row_in = row_ff + ROW_W'(1);
                     end
                  end else if (ch_ff == CH_BACKSPACE) begin
                     if (col_ff != '0) begin
                        col_in    = col_ff - COL_W'(1);
                        au_col    = col_ff - COL_W'(1);
                        ram_wr_en = 1'b1;
                     end
                  end else if (ch_ff == CH_TAB) begin
                     ch_in  = CH_SPACE;
                     tab_in = tab_len[col_ff];
                  end else begin
                     tab_in = TC_W'(1);
                  end
               end
            endcase
         end
         ST_PLAIN: begin
            ram_wr_en   = 1'b1;
            ram_wr_data = {fill_ff, ch_ff};
            tab_in      = tab_ff - TC_W'(1);
            sweep_in    = '0;
            if (col_ff == LAST_COL) begin
               col_in = '0;
               if (row_ff != LAST_ROW) begin
                  row_in = row_ff + ROW_W'(1);
               end
            end else begin
               col_in = col_ff + COL_W'(1);
            end
         end
         ST_SCROLL_RD: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = sweep_ff + ROW_STRIDE;
         end
         ST_SCROLL_WR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = sweep_ff;
            ram_wr_data = ram_rd_data;
            sweep_in    = sweep_ff + ADDR_W'(1);
         end
         ST_SCROLL_FILL, ST_CLEAR_FILL: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = sweep_ff;
            sweep_in    = sweep_ff + ADDR_W'(1);
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_row_in   = row_ff;
               rsp_col_in   = col_ff;
               if (op_ff == OP_READ) begin
                  rsp_char_in = ram_rd_data[CHAR_W-1:0];
                  rsp_attr_in = ram_rd_data[CELL_W-1:CHAR_W];
               end else begin
                  rsp_char_in = '0;
                  rsp_attr_in = '0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         sweep_ff     <= '0;
         row_ff       <= '0;
         col_ff       <= '0;
         tab_ff       <= '0;
         fill_ff      <= RESET_ATTR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         tab_ff       <= tab_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      ch_ff       <= ch_in;
      trow_ff     <= trow_in;
      tcol_ff     <= tcol_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_char_ff <= rsp_char_in;
      rsp_attr_ff <= rsp_attr_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_cur_row   = rsp_row_ff;
   assign rsp_cur_col   = rsp_col_ff;
   assign rsp_cell_char = rsp_char_ff;
   assign rsp_cell_attr = rsp_attr_ff;

endmodule
